### rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types of the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } dlr_state_e;

endpackage

`default_nettype wire

### rtl/dlr_line_if.sv
// ----------------------------------------------------------------------------
// dlr_line_if
// Line request channel: start and end point, signed coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlr_line_if #(
  parameter int COORD_BITS = 6
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

### rtl/dlr_point_if.sv
// ----------------------------------------------------------------------------
// dlr_point_if
// Raster point channel: one point per transaction, last point flagged.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlr_point_if #(
  parameter int COORD_BITS = 6
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

### rtl/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: restoring slope divider followed by a point stepper.
// ----------------------------------------------------------------------------
// A line request is taken only when the unit is idle and its output register
// is empty. The start point is loaded into the output register at once; a
// zero-length line ends there. Otherwise a restoring divider computes the
// slope one quotient bit per cycle, COORD_BITS + FRAC_BITS quotient bits in
// all; then the stepper emits one point per cycle while the sink takes
// them, steps = max(|dx|, |dy|) points, with a single accumulator adder.
// Negative minor positions are truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_unit #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dlr_line_if.sink    line_i,
  dlr_point_if.source point_o
);

  localparam int CW   = COORD_BITS;
  localparam int FW   = FRAC_BITS;
  localparam int NW   = CW + FW;
  localparam int AW   = CW + FW + 1;
  localparam int SW   = FW + 2;
  localparam int CNTW = $clog2(NW + 1);

  dlr_pkg::dlr_state_e state_q, state_d;

  logic [CW-1:0]        major_q, major_d;
  logic                 x_major_q, x_major_d;
  logic                 major_neg_q, major_neg_d;
  logic                 minor_neg_q, minor_neg_d;
  logic [CW-1:0]        remain_q, remain_d;
  logic [NW-1:0]        div_q, div_d;
  logic [CW:0]          rem_q, rem_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic signed [SW-1:0] slope_q, slope_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic                 ovalid_q, ovalid_d;
  logic [CW-1:0]        px_q, px_d;
  logic [CW-1:0]        py_q, py_d;
  logic                 last_q, last_d;

  // request decode
  logic signed [CW:0] dx_w, dy_w, ndx_w, ndy_w;
  logic [CW-1:0]      adx_w, ady_w, steps_w, minor_abs_w, minor_start_w;
  logic               xm_w;

  assign dx_w  = {line_i.end_x[CW-1], line_i.end_x} - {line_i.start_x[CW-1], line_i.start_x};
  assign dy_w  = {line_i.end_y[CW-1], line_i.end_y} - {line_i.start_y[CW-1], line_i.start_y};
  assign ndx_w = -dx_w;
  assign ndy_w = -dy_w;
  assign adx_w = dx_w[CW] ? ndx_w[CW-1:0] : dx_w[CW-1:0];
  assign ady_w = dy_w[CW] ? ndy_w[CW-1:0] : dy_w[CW-1:0];
  assign xm_w  = adx_w >= ady_w;
  assign steps_w       = xm_w ? adx_w : ady_w;
  assign minor_abs_w   = xm_w ? ady_w : adx_w;
  assign minor_start_w = xm_w ? line_i.start_y : line_i.start_x;

  // divider step
  logic [CW:0]   rem_sh_w, rem_sub_w;
  logic          ge_w;
  logic [NW-1:0] div_nx_w;
  logic [SW-1:0] qext_w;

  assign rem_sh_w  = {rem_q[CW-1:0], div_q[NW-1]};
  assign ge_w      = rem_sh_w >= {1'b0, remain_q};
  assign rem_sub_w = rem_sh_w - {1'b0, remain_q};
  assign div_nx_w  = {div_q[NW-2:0], ge_w};
  assign qext_w    = {1'b0, div_nx_w[FW:0]};

  // stepper
  logic signed [AW-1:0] acc_nx_w, acc_neg_w, acc_mag_w;
  logic [CW-1:0]        trunc_w, ntrunc_w, minor_pt_w, major_nx_w;
  logic                 ofree_w;

  assign acc_nx_w   = acc_q + {{(AW-SW){slope_q[SW-1]}}, slope_q};
  assign acc_neg_w  = -acc_nx_w;
  assign acc_mag_w  = acc_nx_w[AW-1] ? acc_neg_w : acc_nx_w;
  assign trunc_w    = acc_mag_w[FW+CW-1:FW];
  assign ntrunc_w   = -trunc_w;
  assign minor_pt_w = acc_nx_w[AW-1] ? ntrunc_w : trunc_w;
  assign major_nx_w = major_neg_q ? major_q - CW'(1) : major_q + CW'(1);
  assign ofree_w    = !ovalid_q || point_o.ready;

  assign line_i.ready       = (state_q == dlr_pkg::ST_IDLE) && !ovalid_q;
  assign point_o.valid      = ovalid_q;
  assign point_o.point_x    = px_q;
  assign point_o.point_y    = py_q;
  assign point_o.last_point = last_q;

  always_comb begin
    state_d     = state_q;
    major_d     = major_q;
    x_major_d   = x_major_q;
    major_neg_d = major_neg_q;
    minor_neg_d = minor_neg_q;
    remain_d    = remain_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    slope_d     = slope_q;
    acc_d       = acc_q;
    ovalid_d    = ovalid_q && !point_o.ready;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    unique case (state_q)
      dlr_pkg::ST_IDLE: begin
        if (line_i.valid && line_i.ready) begin
          ovalid_d    = 1'b1;
          px_d        = line_i.start_x;
          py_d        = line_i.start_y;
          last_d      = (steps_w == '0);
          x_major_d   = xm_w;
          major_d     = xm_w ? line_i.start_x : line_i.start_y;
          major_neg_d = xm_w ? dx_w[CW] : dy_w[CW];
          minor_neg_d = xm_w ? dy_w[CW] : dx_w[CW];
          remain_d    = steps_w;
          div_d       = {minor_abs_w, {FW{1'b0}}};
          rem_d       = '0;
          cnt_d       = CNTW'(NW);
          acc_d       = {minor_start_w[CW-1], minor_start_w, {FW{1'b0}}};
          if (steps_w != '0) begin
            state_d = dlr_pkg::ST_DIV;
          end
        end
      end
      dlr_pkg::ST_DIV: begin
        div_d = div_nx_w;
        rem_d = ge_w ? rem_sub_w : rem_sh_w;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          slope_d = minor_neg_q ? $signed(~qext_w + SW'(1)) : $signed(qext_w);
          state_d = dlr_pkg::ST_EMIT;
        end
      end
      dlr_pkg::ST_EMIT: begin
        if (ofree_w) begin
          ovalid_d = 1'b1;
          acc_d    = acc_nx_w;
          major_d  = major_nx_w;
          remain_d = remain_q - CW'(1);
          px_d     = x_major_q ? major_nx_w : minor_pt_w;
          py_d     = x_major_q ? minor_pt_w : major_nx_w;
          last_d   = (remain_q == CW'(1));
          if (remain_q == CW'(1)) begin
            state_d = dlr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = dlr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dlr_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    major_q     <= major_d;
    x_major_q   <= x_major_d;
    major_neg_q <= major_neg_d;
    minor_neg_q <= minor_neg_d;
    remain_q    <= remain_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    slope_q     <= slope_d;
    acc_q       <= acc_d;
    px_q        <= px_d;
    py_q        <= py_d;
    last_q      <= last_d;
  end

  a_accept_loads_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_i.valid && line_i.ready |=> ovalid_q)
    else $error("accepted line did not load its start point");

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dlr_pkg::ST_DIV |-> cnt_q != '0)
    else $error("divider running with zero count");

  a_emit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dlr_pkg::ST_EMIT |-> !(ovalid_q && last_q) && remain_q != '0)
    else $error("stepper active after last point");

  a_zero_line_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_i.valid && line_i.ready && steps_w == '0 |=> state_q == dlr_pkg::ST_IDLE && last_q)
    else $error("zero-length line left idle");

endmodule

`default_nettype wire
